/* design/ipid_pkg.sv */
// ----------------------------------------------------------------------------
// Incremental PID package
// Shared types, register indexes and saturation helpers for the controller.
// ----------------------------------------------------------------------------
package ipid_pkg;

    // Q32.16 internal value.
    typedef logic signed [47:0] t_q48;

    localparam t_q48 Q48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_q48 Q48_MIN = 48'sh8000_0000_0000;

    // Iteration counts of the serial unit.
    localparam int MUL_STEPS = 48;
    localparam int DIV_STEPS = 52;
    localparam int CNT_W     = 6;

    // Configuration port.
    localparam int APB_AW = 5;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INT_TIME   = 3'd1;
    localparam logic [2:0] REG_DER_TIME   = 3'd2;
    localparam logic [2:0] REG_SAMPLE_PER = 3'd3;
    localparam logic [2:0] REG_PROP_WGT   = 3'd4;
    localparam logic [2:0] REG_DER_WGT    = 3'd5;
    localparam logic [2:0] REG_OUT_MIN    = 3'd6;
    localparam logic [2:0] REG_OUT_MAX    = 3'd7;

    // Input request payload.
    typedef struct packed {
        logic               first_sample;
        logic        [23:0] dt_us;
        logic signed [31:0] measured;
        logic signed [31:0] setpoint;
        logic signed [15:0] present_output;
    } t_in_item;

    // Result request payload.
    typedef struct packed {
        logic signed [15:0] output_level;
    } t_out_item;

    // Command to the serial unit.
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic        neg;
        logic [51:0] opa;
        logic [47:0] opb;
    } t_unit_req;

    // Status of the serial unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // Saturate a widened sum to Q32.16.
    function automatic t_q48 sat50(input logic signed [49:0] v);
        if (v > 50'(Q48_MAX)) begin
            return Q48_MAX;
        end else if (v < 50'(Q48_MIN)) begin
            return Q48_MIN;
        end
        return v[47:0];
    endfunction

    // Magnitude of a Q32.16 value; the most negative value maps to 2^47.
    function automatic logic [47:0] mag48(input t_q48 v);
        return v[47] ? 48'(-v) : v;
    endfunction

endpackage

/* design/ipid_stream_if.sv */
// ----------------------------------------------------------------------------
// Incremental PID stream interface
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface ipid_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/ipid_serial_unit.sv */
// ----------------------------------------------------------------------------
// Incremental PID serial arithmetic unit
// Shift-add multiplier with Q16 rescale and saturation, and a restoring
// divider, sharing one set of working registers, one bit per cycle.
// ----------------------------------------------------------------------------
module ipid_serial_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipid_pkg::t_unit_req   i_req,
    output ipid_pkg::t_unit_stat  o_stat,
    output ipid_pkg::t_q48        o_result
);

    logic                       r_busy;
    logic                       r_done;
    logic                       r_div;
    logic                       r_neg;
    logic [ipid_pkg::CNT_W-1:0] r_cnt;
    logic [47:0]                r_a;
    logic [47:0]                r_hi;
    logic [51:0]                r_lo;

    logic [47:0] n_hi;
    logic [51:0] n_lo;
    logic        last;
    logic [48:0] msum;
    logic [37:0] dtry;
    logic [37:0] dsub;
    logic        dge;

    // One multiply or divide step.
    always_comb begin
        msum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : 49'd0);
        dtry = {r_hi[36:0], r_lo[51]};
        dge  = dtry >= {1'b0, r_a[36:0]};
        dsub = dtry - {1'b0, r_a[36:0]};
        if (r_div) begin
            n_hi = {11'd0, (dge ? dsub[36:0] : dtry[36:0])};
            n_lo = {r_lo[50:0], dge};
        end else begin
            n_hi = msum[48:1];
            n_lo = {4'd0, msum[0], r_lo[47:1]};
        end
        last = r_cnt == (r_div ? ipid_pkg::CNT_W'(ipid_pkg::DIV_STEPS - 1)
                                : ipid_pkg::CNT_W'(ipid_pkg::MUL_STEPS - 1));
    end

    // Sequencing of the iterations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_div  <= i_req.is_div;
                r_neg  <= i_req.neg;
                r_a    <= i_req.is_div ? i_req.opb : i_req.opa[47:0];
                r_lo   <= i_req.is_div ? i_req.opa : {4'd0, i_req.opb};
                r_hi   <= '0;
            end else if (r_busy) begin
                r_hi  <= n_hi;
                r_lo  <= n_lo;
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    logic [95:0] prod;
    logic [79:0] mscaled;
    logic [80:0] mround;
    logic        rnd;

    // Rescale the product by 2^-16 with floor, then saturate; clip quotients.
    always_comb begin
        prod    = {r_hi, r_lo[47:0]};
        mscaled = prod[95:16];
        rnd     = r_neg & (|prod[15:0]);
        mround  = {1'b0, mscaled} + 81'(rnd);
        if (r_div) begin
            o_result = (r_lo > 52'h7FFF_FFFF_FFFF) ? ipid_pkg::Q48_MAX : r_lo[47:0];
        end else if (!r_neg) begin
            o_result = (mscaled > 80'h7FFF_FFFF_FFFF) ? ipid_pkg::Q48_MAX
                                                      : mscaled[47:0];
        end else if (mround > 81'h8000_0000_0000) begin
            o_result = ipid_pkg::Q48_MIN;
        end else begin
            o_result = -ipid_pkg::t_q48'(mround[47:0]);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* design/incremental_pid_controller.sv */
// ----------------------------------------------------------------------------
// Incremental PID controller
// Velocity-form PID with setpoint weights and a filtered derivative.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one tick request: elapsed microseconds, measurement,
//   setpoint, present output level and a first-sample flag. o_out carries
//   the new output level when a control update is due.
//   The APB port writes the eight registers at byte address 4*index; write
//   only while no request is in flight.
//   A tick that does not complete a sample period is absorbed while the
//   block stays idle and gives no result. An update runs on one shared
//   serial unit, one multiply or divide at a time. Derivative time zero
//   skips the derivative steps; integral time zero skips the integral,
//   second-difference and gain steps. The input is not ready during an
//   update and is ready again in the cycle the result becomes valid.
//   The finished level waits in an output register. While that register is
//   still held by a stalled receiver, the next update waits in its last step
//   and the input stays not ready until the level moves out.
//   Reset restores the register defaults and clears all history.
// ----------------------------------------------------------------------------
module incremental_pid_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ipid_stream_if.sink                   i_in,
    ipid_stream_if.source                 o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipid_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL_EP = 4'd1;
    localparam logic [3:0] S_MUL_ED = 4'd2;
    localparam logic [3:0] S_DIV_W  = 4'd3;
    localparam logic [3:0] S_MUL_F  = 4'd4;
    localparam logic [3:0] S_DIV_Q1 = 4'd5;
    localparam logic [3:0] S_DIV_Q2 = 4'd6;
    localparam logic [3:0] S_MUL_I  = 4'd7;
    localparam logic [3:0] S_MUL_D  = 4'd8;
    localparam logic [3:0] S_MUL_K  = 4'd9;
    localparam logic [3:0] S_CLAMP  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // Configuration registers.
    logic        [31:0] r_kp;
    logic        [31:0] r_ti;
    logic        [31:0] r_td;
    logic        [31:0] r_tper;
    logic signed [31:0] r_beta;
    logic signed [31:0] r_gamma;
    logic signed [15:0] r_omin;
    logic signed [15:0] r_omax;

    // Controller history.
    logic        [31:0] r_elapsed;
    ipid_pkg::t_q48     r_pep;
    ipid_pkg::t_q48     r_fp;
    ipid_pkg::t_q48     r_fp2;
    ipid_pkg::t_q48     r_held;

    // Working values of one update.
    logic         [3:0] r_state;
    logic               r_issued;
    logic        [31:0] r_ts;
    logic signed [31:0] r_y;
    logic signed [31:0] r_r;
    ipid_pkg::t_q48     r_e;
    ipid_pkg::t_q48     r_ep;
    ipid_pkg::t_q48     r_ed;
    ipid_pkg::t_q48     r_w;
    ipid_pkg::t_q48     r_edf;
    ipid_pkg::t_q48     r_q1;
    ipid_pkg::t_q48     r_q2;
    ipid_pkg::t_q48     r_sum;
    ipid_pkg::t_q48     r_delta;
    logic signed [15:0] r_level;
    logic               r_out_valid;
    logic signed [15:0] r_out_level;

    ipid_pkg::t_unit_req  w_req;
    ipid_pkg::t_unit_stat w_stat;
    ipid_pkg::t_q48       w_res;

    ipid_serial_unit u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .o_stat   (w_stat),
        .o_result (w_res)
    );

    // Configuration port.
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[4:2])
            ipid_pkg::REG_PROP_GAIN:  prdata = r_kp;
            ipid_pkg::REG_INT_TIME:   prdata = r_ti;
            ipid_pkg::REG_DER_TIME:   prdata = r_td;
            ipid_pkg::REG_SAMPLE_PER: prdata = r_tper;
            ipid_pkg::REG_PROP_WGT:   prdata = r_beta;
            ipid_pkg::REG_DER_WGT:    prdata = r_gamma;
            ipid_pkg::REG_OUT_MIN:    prdata = {16'd0, r_omin};
            ipid_pkg::REG_OUT_MAX:    prdata = {16'd0, r_omax};
            default:                  prdata = '0;
        endcase
    end

    // Time accumulation with saturation.
    logic        in_acc;
    logic [32:0] acc_sum;
    logic [31:0] acc_sat;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid & i_in.ready;
    assign acc_sum    = {1'b0, r_elapsed} + 33'(i_in.payload.dt_us);
    assign acc_sat    = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];

    // Operand selection for the serial unit.
    logic [35:0]    ten_ts;
    ipid_pkg::t_q48 sa;
    ipid_pkg::t_q48 sb;
    logic [51:0]    dvd;
    logic [47:0]    dvs;
    logic           is_div;
    logic           op_state;

    assign ten_ts   = 36'({r_ts, 3'b000}) + 36'({r_ts, 1'b0});
    assign op_state = (r_state != S_IDLE) && (r_state != S_CLAMP) && (r_state != S_DONE);

    always_comb begin
        sa     = '0;
        sb     = '0;
        dvd    = '0;
        dvs    = '0;
        is_div = 1'b0;
        unique case (r_state)
            S_MUL_EP: begin
                sa = 48'(r_beta);
                sb = 48'(r_r);
            end
            S_MUL_ED: begin
                sa = 48'(r_gamma);
                sb = 48'(r_r);
            end
            S_DIV_W: begin
                is_div = 1'b1;
                dvd    = {ten_ts, 16'd0};
                dvs    = 48'(r_td) + 48'(ten_ts);
            end
            S_MUL_F: begin
                sa = ipid_pkg::sat50(50'(r_ed) - 50'(r_fp));
                sb = r_w;
            end
            S_DIV_Q1: begin
                is_div = 1'b1;
                dvd    = 52'({r_ts, 16'd0});
                dvs    = 48'(r_ti);
            end
            S_DIV_Q2: begin
                is_div = 1'b1;
                dvd    = 52'({r_td, 16'd0});
                dvs    = 48'(r_ts);
            end
            S_MUL_I: begin
                sa = r_q1;
                sb = r_e;
            end
            S_MUL_D: begin
                sa = r_q2;
                sb = ipid_pkg::sat50(50'(r_edf) - (50'(r_fp) <<< 1) + 50'(r_fp2));
            end
            S_MUL_K: begin
                sa = 48'(r_kp);
                sb = r_sum;
            end
            default: ;
        endcase
        w_req.start  = op_state && !r_issued;
        w_req.is_div = is_div;
        w_req.neg    = sa[47] ^ sb[47];
        w_req.opa    = is_div ? dvd : {4'd0, ipid_pkg::mag48(sa)};
        w_req.opb    = is_div ? dvs : ipid_pkg::mag48(sb);
    end

    // Output limiting and conversion to an integer level.
    ipid_pkg::t_q48     umax;
    ipid_pkg::t_q48     umin;
    logic signed [48:0] room_hi;
    logic signed [48:0] room_lo;
    ipid_pkg::t_q48     u_next;
    logic               frac_up;
    logic signed [15:0] lvl;

    always_comb begin
        umax    = {{16{r_omax[15]}}, r_omax, 16'd0};
        umin    = {{16{r_omin[15]}}, r_omin, 16'd0};
        room_hi = 49'(umax) - 49'(r_held);
        room_lo = 49'(umin) - 49'(r_held);
        if (49'(r_delta) > room_hi) begin
            u_next = umax;
        end else if (49'(r_delta) < room_lo) begin
            u_next = umin;
        end else begin
            u_next = r_held + r_delta;
        end
        frac_up = u_next[47] & (|u_next[15:0]);
        lvl     = u_next[31:16] + 16'(frac_up);
    end

    // Update sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= '0;
            r_ti        <= '0;
            r_td        <= '0;
            r_tper      <= '0;
            r_beta      <= 32'sd65536;
            r_gamma     <= '0;
            r_omin      <= '0;
            r_omax      <= 16'sd100;
            r_elapsed   <= '0;
            r_pep       <= '0;
            r_fp        <= '0;
            r_fp2       <= '0;
            r_held      <= '0;
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    ipid_pkg::REG_PROP_GAIN:  r_kp    <= pwdata;
                    ipid_pkg::REG_INT_TIME:   r_ti    <= pwdata;
                    ipid_pkg::REG_DER_TIME:   r_td    <= pwdata;
                    ipid_pkg::REG_SAMPLE_PER: r_tper  <= pwdata;
                    ipid_pkg::REG_PROP_WGT:   r_beta  <= pwdata;
                    ipid_pkg::REG_DER_WGT:    r_gamma <= pwdata;
                    ipid_pkg::REG_OUT_MIN:    r_omin  <= pwdata[15:0];
                    ipid_pkg::REG_OUT_MAX:    r_omax  <= pwdata[15:0];
                    default: ;
                endcase
            end

            // The last step refills the output register itself.
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            if (w_req.start) begin
                r_issued <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.payload.first_sample) begin
                            r_pep  <= '0;
                            r_fp   <= '0;
                            r_fp2  <= '0;
                            r_held <= {{16{i_in.payload.present_output[15]}},
                                       i_in.payload.present_output, 16'd0};
                        end
                        if (acc_sat <= r_tper) begin
                            r_elapsed <= acc_sat;
                        end else begin
                            r_elapsed <= '0;
                            r_ts      <= acc_sat;
                            r_y       <= i_in.payload.measured;
                            r_r       <= i_in.payload.setpoint;
                            r_e       <= 48'(i_in.payload.setpoint)
                                         - 48'(i_in.payload.measured);
                            r_delta   <= '0;
                            r_state   <= S_MUL_EP;
                        end
                    end
                end
                S_MUL_EP: begin
                    if (w_stat.done) begin
                        r_issued <= 1'b0;
                        r_ep     <= ipid_pkg::sat50(50'(w_res) - 50'(r_y));
                        if (r_td != '0) begin
                            r_state <= S_MUL_ED;
                        end else begin
                            r_fp    <= '0;
                            r_fp2   <= '0;
                            r_edf   <= '0;
                            r_state <= (r_ti != '0) ? S_DIV_Q1 : S_CLAMP;
                        end
                    end
                end
                S_MUL_ED: begin
                    if (w_stat.done) begin
                        r_issued <= 1'b0;
                        r_ed     <= ipid_pkg::sat50(50'(w_res) - 50'(r_y));
                        r_state  <= S_DIV_W;
                    end
                end
                S_DIV_W: begin
                    if (w_stat.done) begin
                        r_issued <= 1'b0;
                        r_w      <= w_res;
                        r_state  <= S_MUL_F;
                    end
                end
                S_MUL_F: begin
                    if (w_stat.done) begin
                        r_issued <= 1'b0;
                        r_edf    <= ipid_pkg::sat50(50'(r_fp) + 50'(w_res));
                        r_state  <= (r_ti != '0) ? S_DIV_Q1 : S_CLAMP;
                    end
                end
                S_DIV_Q1: begin
                    if (w_stat.done) begin
                        r_issued <= 1'b0;
                        r_q1     <= w_res;
                        r_state  <= S_DIV_Q2;
                    end
                end
                S_DIV_Q2: begin
                    if (w_stat.done) begin
                        r_issued <= 1'b0;
                        r_q2     <= w_res;
                        r_sum    <= ipid_pkg::sat50(50'(r_ep) - 50'(r_pep));
                        r_state  <= S_MUL_I;
                    end
                end
                S_MUL_I: begin
                    if (w_stat.done) begin
                        r_issued <= 1'b0;
                        r_sum    <= ipid_pkg::sat50(50'(r_sum) + 50'(w_res));
                        r_state  <= S_MUL_D;
                    end
                end
                S_MUL_D: begin
                    if (w_stat.done) begin
                        r_issued <= 1'b0;
                        r_sum    <= ipid_pkg::sat50(50'(r_sum) + 50'(w_res));
                        r_state  <= S_MUL_K;
                    end
                end
                S_MUL_K: begin
                    if (w_stat.done) begin
                        r_issued <= 1'b0;
                        r_delta  <= w_res;
                        r_state  <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_held  <= u_next;
                    r_pep   <= r_ep;
                    r_fp2   <= r_fp;
                    r_fp    <= r_edf;
                    r_level <= lvl;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_level <= r_level;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid                = r_out_valid;
    assign o_out.payload.output_level = r_out_level;

    // The sequencer never restarts the unit while it is still iterating.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_stat.busy)
        else $error("serial unit restarted while busy");

    // A finished operation always belongs to an issued step.
    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> r_issued)
        else $error("serial unit finished without an issued step");

    // With ordered limits the held output lands inside them after an update.
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_omin <= r_omax) |-> (r_held >= umin && r_held <= umax))
        else $error("held output outside the configured limits");

    // Reset leaves no stale result pending.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result pending after reset");

endmodule

/* dv/tb_incremental_pid_controller.sv */
// ----------------------------------------------------------------------------
// Incremental PID controller testbench
// Drives tick requests and register writes, predicts each output level with
// an independent fixed-point model and checks every result request in order.
// ----------------------------------------------------------------------------

// Expected-level store with its own model of the controller.
class pid_scoreboard;
    bit [31:0] kp, ti, td, tsp;
    bit signed [31:0] beta, gamma;
    bit signed [15:0] umin_r, umax_r;
    bit [31:0] acc_us;
    longint prev_ep, edf1, edf2, held;
    bit signed [15:0] levels_q[$];
    int errors;

    function new();
        kp = 0; ti = 0; td = 0; tsp = 0;
        beta = 32'sd65536; gamma = 0;
        umin_r = 0; umax_r = 16'sd100;
        acc_us = 0; prev_ep = 0; edf1 = 0; edf2 = 0; held = 0;
        errors = 0;
    endfunction

    function void write_reg(int idx, bit [31:0] v);
        case (idx)
            ipid_pkg::REG_PROP_GAIN:  kp = v;
            ipid_pkg::REG_INT_TIME:   ti = v;
            ipid_pkg::REG_DER_TIME:   td = v;
            ipid_pkg::REG_SAMPLE_PER: tsp = v;
            ipid_pkg::REG_PROP_WGT:   beta = v;
            ipid_pkg::REG_DER_WGT:    gamma = v;
            ipid_pkg::REG_OUT_MIN:    umin_r = v[15:0];
            ipid_pkg::REG_OUT_MAX:    umax_r = v[15:0];
            default: ;
        endcase
    endfunction

    static function longint clip(logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -128'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return longint'(v);
    endfunction

    // Q16 product with floor, saturated to Q32.16.
    static function longint qprod(longint a, longint b);
        logic signed [127:0] p;
        p = 128'(signed'(a)) * 128'(signed'(b));
        return clip(p >>> 16);
    endfunction

    // Note an accepted tick; queue a level if an update is due.
    function void note_tick(ipid_pkg::t_in_item it);
        longint y, r, ep, e, edf, delta, hi, lo, u, d2, sum, ed;
        logic [63:0] tsv, w, q1, q2;
        bit [32:0] s;
        y = longint'(it.measured); r = longint'(it.setpoint);
        edf = 0; delta = 0;
        if (it.first_sample) begin
            prev_ep = 0; edf1 = 0; edf2 = 0;
            held = longint'(it.present_output) * 65536;
        end
        s = {1'b0, acc_us} + {9'd0, it.dt_us};
        acc_us = s[32] ? 32'hFFFF_FFFF : s[31:0];
        if (acc_us <= tsp) return;
        tsv = acc_us; acc_us = 0;
        ep = clip(qprod(longint'(beta), r) - y);
        e = r - y;
        if (td != 0) begin
            ed = clip(qprod(longint'(gamma), r) - y);
            w = (10 * tsv * 65536) / (64'(td) + 10 * tsv);
            edf = clip(edf1 + qprod(clip(ed - edf1), longint'(w)));
        end else begin
            edf1 = 0; edf2 = 0;
        end
        if (ti != 0) begin
            q1 = (tsv << 16) / ti;
            q2 = (64'(td) << 16) / tsv;
            if (q1 > 64'h7FFF_FFFF_FFFF) q1 = 64'h7FFF_FFFF_FFFF;
            if (q2 > 64'h7FFF_FFFF_FFFF) q2 = 64'h7FFF_FFFF_FFFF;
            d2 = clip(128'(edf) - 2 * 128'(edf1) + 128'(edf2));
            sum = clip(ep - prev_ep);
            sum = clip(sum + qprod(longint'(q1), e));
            sum = clip(sum + qprod(longint'(q2), d2));
            delta = qprod(longint'({32'd0, kp}), sum);
        end
        hi = longint'(umax_r) * 65536;
        lo = longint'(umin_r) * 65536;
        if (delta > hi - held) u = hi;
        else if (delta < lo - held) u = lo;
        else u = held + delta;
        held = u; prev_ep = ep; edf2 = edf1; edf1 = edf;
        levels_q.push_back(16'(u / 65536));
    endfunction

    // Compare one result request with the oldest expected level.
    function void check_level(ipid_pkg::t_out_item got);
        bit signed [15:0] exp_l;
        if (levels_q.size() == 0) begin
            $error("output_level: none expected, actual %0d", got.output_level);
            errors++;
            return;
        end
        exp_l = levels_q.pop_front();
        if (exp_l !== got.output_level) begin
            $error("output_level: expected %0d, actual %0d", exp_l, got.output_level);
            errors++;
        end
    endfunction
endclass

module tb_incremental_pid_controller;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ipid_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    ipid_stream_if #(.t_payload(ipid_pkg::t_in_item)) tick_if ();
    ipid_stream_if #(.t_payload(ipid_pkg::t_out_item)) level_if ();

    pid_scoreboard sb = new();

    incremental_pid_controller dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(tick_if.sink), .o_out(level_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        tick_if.valid = 0;
        tick_if.payload = '0;
        level_if.ready = 0;
    end

    // Gap length: mostly short, now and then long.
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 0;
        if (k < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Register write: setup then access cycle.
    task automatic reg_write(int idx, bit [31:0] v);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1;
        paddr = ipid_pkg::APB_AW'(idx * 4); pwdata = v;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // Present one tick request and hold it until accepted.
    task automatic send_tick(ipid_pkg::t_in_item it);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        tick_if.valid = 1;
        tick_if.payload = it;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
        sb.note_tick(it);
        @(negedge i_clk);
        tick_if.valid = 0;
    endtask

    // Wait until all expected levels are back and the block is quiet.
    task automatic drain();
        while (sb.levels_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    function automatic ipid_pkg::t_in_item rand_tick(int fs_pct, int dt_hi);
        ipid_pkg::t_in_item it;
        int k;
        it.first_sample = ($urandom_range(0, 99) < fs_pct);
        k = $urandom_range(0, 19);
        it.dt_us = (k == 0) ? 24'hFFFFFF : 24'($urandom_range(0, dt_hi));
        k = $urandom_range(0, 9);
        it.measured = (k < 7) ? 32'($signed(32'($urandom_range(0, 1 << 22))) - (1 << 21))
                              : 32'($urandom());
        k = $urandom_range(0, 9);
        it.setpoint = (k < 7) ? 32'($signed(32'($urandom_range(0, 1 << 22))) - (1 << 21))
                              : 32'($urandom());
        it.present_output = 16'($urandom());
        return it;
    endfunction

    // Result side: random back-pressure, check on acceptance.
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            g = gap_len();
            @(negedge i_clk);
            level_if.ready = 0;
            repeat (g) @(negedge i_clk);
            level_if.ready = 1;
            @(posedge i_clk);
            while (!level_if.valid) @(posedge i_clk);
            sb.check_level(level_if.payload);
        end
    end

    // Stimulus and final verdict.
    initial begin
        ipid_pkg::t_in_item it;
        int ph, n;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: reset defaults with Ti zero, then extremes.
        it = '0; it.first_sample = 1; it.dt_us = 24'd5; it.present_output = 16'sd50;
        send_tick(it);
        it.first_sample = 0; it.dt_us = 0;
        send_tick(it);
        drain();
        reg_write(ipid_pkg::REG_PROP_GAIN, 32'h0001_0000);
        reg_write(ipid_pkg::REG_INT_TIME, 32'd1000);
        reg_write(ipid_pkg::REG_DER_TIME, 32'd0);
        reg_write(ipid_pkg::REG_SAMPLE_PER, 32'd100);
        reg_write(ipid_pkg::REG_OUT_MIN, 32'hFFFF_8000);
        reg_write(ipid_pkg::REG_OUT_MAX, 32'h0000_7FFF);
        it = '0; it.first_sample = 1; it.dt_us = 24'd50; it.present_output = 16'sh8000;
        send_tick(it);
        it.first_sample = 0; it.dt_us = 24'd60; it.setpoint = 32'sh7FFF_FFFF;
        it.measured = 32'sh8000_0000;
        send_tick(it);
        it.dt_us = 24'hFFFFFF; it.setpoint = 32'sh8000_0000; it.measured = 32'sh7FFF_FFFF;
        send_tick(it);
        it.present_output = 16'sh7FFF; it.first_sample = 1;
        send_tick(it);
        drain();
        reg_write(ipid_pkg::REG_DER_TIME, 32'hFFFF_FFFF);
        reg_write(ipid_pkg::REG_PROP_WGT, 32'h8000_0000);
        reg_write(ipid_pkg::REG_DER_WGT, 32'h7FFF_FFFF);
        reg_write(ipid_pkg::REG_SAMPLE_PER, 32'hFFFF_FFFF);
        // Elapsed time saturates and can never exceed the all-ones period.
        for (n = 0; n < 260; n++) begin
            it = rand_tick(0, 24'hFFFFFF); it.dt_us = 24'hFFFFFF;
            send_tick(it);
        end
        drain();
        reg_write(ipid_pkg::REG_SAMPLE_PER, 32'd0);
        reg_write(ipid_pkg::REG_PROP_GAIN, 32'hFFFF_FFFF);
        it = rand_tick(100, 10); send_tick(it);
        it = rand_tick(0, 10); send_tick(it);
        // Inverted limits: the max check comes first, so max wins where both limits are crossed.
        drain();
        reg_write(ipid_pkg::REG_OUT_MIN, 32'd10);
        reg_write(ipid_pkg::REG_OUT_MAX, 32'hFFFF_FFF6);
        it = rand_tick(100, 10); send_tick(it);
        it = rand_tick(0, 10); send_tick(it);
        drain();

        // Random phases with varied settings.
        for (ph = 0; ph < 12; ph++) begin
            reg_write(ipid_pkg::REG_PROP_GAIN, ($urandom_range(0, 3) == 0) ? $urandom()
                                     : 32'($urandom_range(0, 32'h0004_0000)));
            reg_write(ipid_pkg::REG_INT_TIME, (ph % 4 == 3) ? 32'd0
                                    : 32'($urandom_range(1, 20000)));
            reg_write(ipid_pkg::REG_DER_TIME, (ph % 3 == 1) ? 32'd0
                                    : 32'($urandom_range(1, 50000)));
            reg_write(ipid_pkg::REG_SAMPLE_PER, 32'($urandom_range(0, 2000)));
            reg_write(ipid_pkg::REG_PROP_WGT, $urandom());
            reg_write(ipid_pkg::REG_DER_WGT, $urandom());
            reg_write(ipid_pkg::REG_OUT_MIN,
                      32'($signed(32'($urandom_range(0, 400))) - 300));
            reg_write(ipid_pkg::REG_OUT_MAX, 32'($urandom_range(0, 400)));
            it = rand_tick(100, 1000); send_tick(it);
            for (n = 0; n < 95; n++) begin
                it = rand_tick(3, 1500);
                send_tick(it);
            end
            drain();
        end
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
